### src/graph_articulation_point_analyzer_core_defines.svh
// assertion macros for the articulation point analyzer checker
`ifndef GRAPH_ARTICULATION_POINT_ANALYZER_CORE_DEFINES_SVH
`define GRAPH_ARTICULATION_POINT_ANALYZER_CORE_DEFINES_SVH
// same-cycle implication
`define GAPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GAPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/gapa_pkg.sv
// package: types and constants of the articulation point analyzer
package gapa_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int MAX_EDGES_DEF    = 128;
  localparam int V_BITS           = 6;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_ANALYZE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_RSVD    = 2'd3;

  localparam logic [2:0] KIND_ACK    = 3'd0;
  localparam logic [2:0] KIND_REJECT = 3'd1;
  localparam logic [2:0] KIND_COMPS  = 3'd2;
  localparam logic [2:0] KIND_TOP    = 3'd3;
  localparam logic [2:0] KIND_CUTS   = 3'd4;
  localparam logic [2:0] KIND_BEST   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_RD,
    ST_CHK,
    ST_VISIT,
    ST_POP1,
    ST_POP2,
    ST_EM_COMP,
    ST_EM_TOP,
    ST_EM_CUT,
    ST_ROOT2,
    ST_EM_BEST
  } state_t;

endpackage

### src/graph_articulation_point_analyzer_core.sv
// top level: edge store and depth-first articulation point analyzer
// Usage:
//   in_* channel carries one command beat (add edge, analyze, clear) with
//   valid/stall; out_* channel returns result beats with valid/stall, and
//   out_last marks the final beat of a command. cfg_* writes vertex_count
//   (always ready); write it only while the block is idle.
//   Add edge, clear and unused op: one result beat the cycle after accept,
//   and such commands are accepted every cycle while out is not stalled.
//   Analyze: the walk scans the edge store through its single read port,
//   with a read state and a check state per stored edge end, each vertex's
//   neighbor list once per pass; two passes (Tarjan walk and remaining-size
//   walk). No command is accepted until the last beat is loaded.
//   Reset (rst_n low, synchronous) empties the store, sets vertex_count
//   to 1 and drops any pending result. A stalled result holds its value,
//   and the sequencer waits while the output register is full and stalled.
module graph_articulation_point_analyzer_core #(
  parameter int MAX_VERTICES = gapa_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gapa_pkg::MAX_EDGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [5:0] in_end_a,
  input  logic [5:0] in_end_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [5:0] out_value,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  localparam int VB  = gapa_pkg::V_BITS;
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int SPW = $clog2(MAX_VERTICES + 1);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW  = $clog2(MAX_EDGES + 1);
  localparam int SW  = $clog2(2 * MAX_EDGES + 1);

  gapa_pkg::state_t state_r, state_nxt;

  logic [VB-1:0] vcnt_r;
  logic [FW-1:0] fill_r, fill_nxt;

  // edge store
  logic [2*VB-1:0] edge_mem [MAX_EDGES];
  logic [2*VB-1:0] ed_q;
  logic            mem_we;
  logic [EW-1:0]   mem_waddr, mem_raddr;
  logic [2*VB-1:0] mem_wdata;

  // per-vertex state
  logic [VB-1:0] disc_r [MAX_VERTICES];
  logic [VB-1:0] disc_nxt [MAX_VERTICES];
  logic [VB-1:0] low_r [MAX_VERTICES];
  logic [VB-1:0] low_nxt [MAX_VERTICES];
  logic [VB-1:0] par_r [MAX_VERTICES];
  logic [VB-1:0] par_nxt [MAX_VERTICES];
  logic [VB-1:0] top_r [MAX_VERTICES];
  logic [VB-1:0] top_nxt [MAX_VERTICES];
  logic [VB-1:0] kid_r [MAX_VERTICES];
  logic [VB-1:0] kid_nxt [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] seen_r, seen_nxt;
  logic [MAX_VERTICES-1:0] cut_r, cut_nxt;
  logic [MAX_VERTICES-1:0] topf_r, topf_nxt;

  // walk stack, frames below the top one
  logic [VB-1:0] stk_v_r [MAX_VERTICES];
  logic [VB-1:0] stk_v_nxt [MAX_VERTICES];
  logic [SW-1:0] stk_s_r [MAX_VERTICES];
  logic [SW-1:0] stk_s_nxt [MAX_VERTICES];

  logic [VB-1:0]  cur_v_r, cur_v_nxt;
  logic [SW-1:0]  cur_s_r, cur_s_nxt;
  logic [VB-1:0]  w_r, w_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [VB-1:0]  r_r, r_nxt;
  logic [VB-1:0]  vclk_r, vclk_nxt;
  logic [VB-1:0]  comps_r, comps_nxt;
  logic [VB-1:0]  cuts_r, cuts_nxt;
  logic [VB-1:0]  size_r, size_nxt;
  logic [VB-1:0]  best_r, best_nxt;
  logic [VB-1:0]  tv_r, tv_nxt;
  logic [VB-1:0]  lv_r, lv_nxt;
  logic           mode_r, mode_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [VB-1:0] out_value_r, out_value_nxt;
  logic       out_last_r, out_last_nxt;

  logic          out_free;
  logic          emit_req;
  logic [2:0]    emit_kind;
  logic [VB-1:0] emit_value;
  logic          emit_last;

  logic [VB-1:0]  n_eff;
  logic [VB-1:0]  cv_dec, w_dec, r_dec, t_dec;
  logic [VW-1:0]  ci, wi, ri, ti, fa, da;
  logic [SPW-1:0] sp_m1, sp_m2;
  logic [VW-1:0]  pi, qi;
  logic [SW-1:0]  s_half, s_lim;
  logic [VB-1:0]  ea, eb, vclk_inc, disc_rd;
  logic           seen_f, cut_f, topf_f, cut_c;

  assign cfg_ready = 1'b1;
  assign n_eff = (vcnt_r > VB'(MAX_VERTICES)) ? VB'(MAX_VERTICES) : vcnt_r;

  assign cv_dec = cur_v_r - VB'(1);
  assign w_dec  = w_r - VB'(1);
  assign r_dec  = r_r - VB'(1);
  assign ci     = cv_dec[VW-1:0];
  assign wi     = w_dec[VW-1:0];
  assign ri     = r_dec[VW-1:0];
  assign t_dec  = top_r[ci] - VB'(1);
  assign ti     = t_dec[VW-1:0];
  assign sp_m1  = sp_r - SPW'(1);
  assign sp_m2  = sp_r - SPW'(2);
  assign pi     = sp_m1[VW-1:0];
  assign qi     = sp_m2[VW-1:0];
  assign s_half = cur_s_r >> 1;
  assign s_lim  = SW'({fill_r, 1'b0});
  assign ea     = ed_q[2*VB-1:VB];
  assign eb     = ed_q[VB-1:0];
  assign vclk_inc = vclk_r + VB'(1);

  // one read address per flag and time array
  assign fa = (state_r == gapa_pkg::ST_VISIT) ? wi :
              (state_r == gapa_pkg::ST_POP2) ? ci : ri;
  assign da = (state_r == gapa_pkg::ST_VISIT) ? wi : ci;
  assign seen_f  = seen_r[fa];
  assign cut_f   = cut_r[fa];
  assign topf_f  = topf_r[fa];
  assign disc_rd = disc_r[da];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == gapa_pkg::ST_IDLE) && out_free);

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    disc_nxt   = disc_r;
    low_nxt    = low_r;
    par_nxt    = par_r;
    top_nxt    = top_r;
    kid_nxt    = kid_r;
    seen_nxt   = seen_r;
    cut_nxt    = cut_r;
    topf_nxt   = topf_r;
    stk_v_nxt  = stk_v_r;
    stk_s_nxt  = stk_s_r;
    cur_v_nxt  = cur_v_r;
    cur_s_nxt  = cur_s_r;
    w_nxt      = w_r;
    sp_nxt     = sp_r;
    r_nxt      = r_r;
    vclk_nxt   = vclk_r;
    comps_nxt  = comps_r;
    cuts_nxt   = cuts_r;
    size_nxt   = size_r;
    best_nxt   = best_r;
    tv_nxt     = tv_r;
    lv_nxt     = lv_r;
    mode_nxt   = mode_r;
    mem_we     = 1'b0;
    mem_waddr  = fill_r[EW-1:0];
    mem_wdata  = {in_end_a, in_end_b};
    mem_raddr  = s_half[EW-1:0];
    emit_req   = 1'b0;
    emit_kind  = gapa_pkg::KIND_ACK;
    emit_value = '0;
    emit_last  = 1'b0;
    cut_c      = 1'b0;

    case (state_r)
      gapa_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          emit_req  = 1'b1;
          emit_last = 1'b1;
          case (in_op)
            gapa_pkg::OP_ADD: begin
              if (in_end_a != '0 && in_end_a <= n_eff && in_end_b != '0 &&
                  in_end_b <= n_eff && fill_r < FW'(MAX_EDGES)) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + FW'(1);
              end else begin
                emit_kind = gapa_pkg::KIND_REJECT;
              end
            end
            gapa_pkg::OP_CLEAR: begin
              fill_nxt = '0;
            end
            gapa_pkg::OP_ANALYZE: begin
              emit_req = 1'b0;
              for (int i = 0; i < MAX_VERTICES; i++) begin
                par_nxt[i] = '0;
              end
              seen_nxt  = '0;
              cut_nxt   = '0;
              topf_nxt  = '0;
              vclk_nxt  = '0;
              comps_nxt = '0;
              cuts_nxt  = '0;
              best_nxt  = '0;
              sp_nxt    = '0;
              r_nxt     = VB'(1);
              mode_nxt  = 1'b0;
              state_nxt = gapa_pkg::ST_ROOT;
            end
            default: begin
              emit_kind = gapa_pkg::KIND_REJECT;
            end
          endcase
        end
      end
      gapa_pkg::ST_ROOT: begin
        if (r_r > n_eff) begin
          state_nxt = gapa_pkg::ST_EM_COMP;
        end else if (!seen_f) begin
          seen_nxt[ri] = 1'b1;
          vclk_nxt     = vclk_inc;
          disc_nxt[ri] = vclk_inc;
          low_nxt[ri]  = vclk_inc;
          top_nxt[ri]  = r_r;
          kid_nxt[ri]  = '0;
          cur_v_nxt    = r_r;
          cur_s_nxt    = '0;
          sp_nxt       = SPW'(1);
          state_nxt    = gapa_pkg::ST_RD;
        end else begin
          r_nxt = r_r + VB'(1);
        end
      end
      gapa_pkg::ST_RD: begin
        if (cur_s_r >= s_lim) begin
          state_nxt = gapa_pkg::ST_POP1;
        end else begin
          state_nxt = gapa_pkg::ST_CHK;
        end
      end
      gapa_pkg::ST_CHK: begin
        cur_s_nxt = cur_s_r + SW'(1);
        state_nxt = gapa_pkg::ST_RD;
        if (ea != '0 && ea <= n_eff && eb != '0 && eb <= n_eff) begin
          if (!cur_s_r[0] && ea == cur_v_r) begin
            w_nxt     = eb;
            state_nxt = gapa_pkg::ST_VISIT;
          end else if (cur_s_r[0] && eb == cur_v_r) begin
            w_nxt     = ea;
            state_nxt = gapa_pkg::ST_VISIT;
          end
        end
      end
      gapa_pkg::ST_VISIT: begin
        state_nxt = gapa_pkg::ST_RD;
        if (!mode_r) begin
          if (!seen_f) begin
            kid_nxt[ci]   = kid_r[ci] + VB'(1);
            par_nxt[wi]   = cur_v_r;
            seen_nxt[wi]  = 1'b1;
            vclk_nxt      = vclk_inc;
            disc_nxt[wi]  = vclk_inc;
            low_nxt[wi]   = vclk_inc;
            top_nxt[wi]   = w_r;
            kid_nxt[wi]   = '0;
            stk_v_nxt[pi] = cur_v_r;
            stk_s_nxt[pi] = cur_s_r;
            cur_v_nxt     = w_r;
            cur_s_nxt     = '0;
            sp_nxt        = sp_r + SPW'(1);
          end else if (w_r != par_r[ci] && disc_rd < low_r[ci]) begin
            low_nxt[ci] = disc_rd;
          end
        end else if (!seen_f && !cut_f) begin
          seen_nxt[wi]  = 1'b1;
          stk_v_nxt[pi] = cur_v_r;
          stk_s_nxt[pi] = cur_s_r;
          cur_v_nxt     = w_r;
          cur_s_nxt     = '0;
          sp_nxt        = sp_r + SPW'(1);
          size_nxt      = size_r + VB'(1);
        end
      end
      gapa_pkg::ST_POP1: begin
        if (sp_r == SPW'(1)) begin
          sp_nxt = '0;
          r_nxt  = r_r + VB'(1);
          if (!mode_r) begin
            topf_nxt[ti] = 1'b1;
            comps_nxt    = comps_r + VB'(1);
            state_nxt    = gapa_pkg::ST_ROOT;
          end else begin
            if (size_r > best_r) begin
              best_nxt = size_r;
            end
            state_nxt = gapa_pkg::ST_ROOT2;
          end
        end else begin
          sp_nxt    = sp_m1;
          cur_v_nxt = stk_v_r[qi];
          cur_s_nxt = stk_s_r[qi];
          if (!mode_r) begin
            tv_nxt    = top_r[ci];
            lv_nxt    = low_r[ci];
            state_nxt = gapa_pkg::ST_POP2;
          end else begin
            state_nxt = gapa_pkg::ST_RD;
          end
        end
      end
      gapa_pkg::ST_POP2: begin
        if (tv_r > top_r[ci]) begin
          top_nxt[ci] = tv_r;
        end
        if (lv_r < low_r[ci]) begin
          low_nxt[ci] = lv_r;
        end
        if (par_r[ci] == '0) begin
          cut_c = kid_r[ci] > VB'(1);
        end else begin
          cut_c = lv_r >= disc_rd;
        end
        if (cut_c && !cut_f) begin
          cut_nxt[ci] = 1'b1;
          cuts_nxt    = cuts_r + VB'(1);
        end
        state_nxt = gapa_pkg::ST_RD;
      end
      gapa_pkg::ST_EM_COMP: begin
        emit_req   = 1'b1;
        emit_kind  = gapa_pkg::KIND_COMPS;
        emit_value = comps_r;
        if (out_free) begin
          r_nxt     = VB'(1);
          state_nxt = gapa_pkg::ST_EM_TOP;
        end
      end
      gapa_pkg::ST_EM_TOP: begin
        if (r_r > n_eff) begin
          state_nxt = gapa_pkg::ST_EM_CUT;
        end else if (topf_f) begin
          emit_req   = 1'b1;
          emit_kind  = gapa_pkg::KIND_TOP;
          emit_value = r_r;
          if (out_free) begin
            r_nxt = r_r + VB'(1);
          end
        end else begin
          r_nxt = r_r + VB'(1);
        end
      end
      gapa_pkg::ST_EM_CUT: begin
        emit_req   = 1'b1;
        emit_kind  = gapa_pkg::KIND_CUTS;
        emit_value = cuts_r;
        if (out_free) begin
          seen_nxt  = '0;
          r_nxt     = VB'(1);
          mode_nxt  = 1'b1;
          state_nxt = gapa_pkg::ST_ROOT2;
        end
      end
      gapa_pkg::ST_ROOT2: begin
        if (r_r > n_eff) begin
          state_nxt = gapa_pkg::ST_EM_BEST;
        end else if (!seen_f && !cut_f) begin
          seen_nxt[ri] = 1'b1;
          cur_v_nxt    = r_r;
          cur_s_nxt    = '0;
          sp_nxt       = SPW'(1);
          size_nxt     = VB'(1);
          state_nxt    = gapa_pkg::ST_RD;
        end else begin
          r_nxt = r_r + VB'(1);
        end
      end
      gapa_pkg::ST_EM_BEST: begin
        emit_req   = 1'b1;
        emit_kind  = gapa_pkg::KIND_BEST;
        emit_value = best_r;
        emit_last  = 1'b1;
        if (out_free) begin
          state_nxt = gapa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gapa_pkg::ST_IDLE;
      end
    endcase

    // output register
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (emit_req && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = emit_kind;
      out_value_nxt = emit_value;
      out_last_nxt  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gapa_pkg::ST_IDLE;
      vcnt_r      <= VB'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    disc_r      <= disc_nxt;
    low_r       <= low_nxt;
    par_r       <= par_nxt;
    top_r       <= top_nxt;
    kid_r       <= kid_nxt;
    seen_r      <= seen_nxt;
    cut_r       <= cut_nxt;
    topf_r      <= topf_nxt;
    stk_v_r     <= stk_v_nxt;
    stk_s_r     <= stk_s_nxt;
    cur_v_r     <= cur_v_nxt;
    cur_s_r     <= cur_s_nxt;
    w_r         <= w_nxt;
    sp_r        <= sp_nxt;
    r_r         <= r_nxt;
    vclk_r      <= vclk_nxt;
    comps_r     <= comps_nxt;
    cuts_r      <= cuts_nxt;
    size_r      <= size_nxt;
    best_r      <= best_nxt;
    tv_r        <= tv_nxt;
    lv_r        <= lv_nxt;
    mode_r      <= mode_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // edge store memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      edge_mem[mem_waddr] <= mem_wdata;
    end
    ed_q <= edge_mem[mem_raddr];
  end

endmodule

### src/gapa_checker.sv
// checker on the analyzer ports, bound to the top level
`include "graph_articulation_point_analyzer_core_defines.svh"

module gapa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic [5:0] out_value,
  input logic       out_last
);

  `GAPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_last), "stalled result beat changed")
  `GAPA_ASSERT_SAME(a_no_accept_when_full, out_valid && out_stall, in_stall, "command accepted while result beat stalled")
  `GAPA_ASSERT_SAME(a_status_zero, out_valid && (out_kind == gapa_pkg::KIND_ACK || out_kind == gapa_pkg::KIND_REJECT), out_value == '0 && out_last, "ack or reject beat with value or not last")
  `GAPA_ASSERT_SAME(a_last_kind, out_valid && (out_kind == gapa_pkg::KIND_COMPS || out_kind == gapa_pkg::KIND_TOP || out_kind == gapa_pkg::KIND_CUTS), !out_last, "analysis beat marked last too early")

endmodule

bind graph_articulation_point_analyzer_core gapa_checker u_gapa_checker (.*);

### verif/graph_articulation_point_analyzer_core_test.sv
// testbench for the articulation point analyzer: directed table, random graphs, predicted results
module graph_articulation_point_analyzer_core_test;

  localparam int NV = gapa_pkg::MAX_VERTICES_DEF;
  localparam int NE = gapa_pkg::MAX_EDGES_DEF;
  localparam int WATCH_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] value;
    logic       last;
  } beat_t;

  typedef struct {
    logic [1:0] op;
    logic [5:0] a;
    logic [5:0] b;
    logic       has_exp;
    logic [2:0] kind;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_op = 0;
  logic [5:0] in_end_a = 0;
  logic [5:0] in_end_b = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_kind;
  logic [5:0] out_value;
  logic out_last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [5:0] cfg_data = 0;

  graph_articulation_point_analyzer_core dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state
  logic [5:0] vcount;
  logic [5:0] store_a [NE];
  logic [5:0] store_b [NE];
  int fill;
  int disc [NV+1];
  int lowv [NV+1];
  int par [NV+1];
  int kids [NV+1];
  int topv [NV+1];
  bit seen [NV+1];
  bit cutf [NV+1];
  bit topf [NV+1];
  int stk_v [NV+1];
  int stk_s [NV+1];
  int clock_t;

  beat_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int long_hold = 0;
  bit hold_req = 0;

  function automatic int next_nbr(int v, ref int pos, input int n);
    int s, a, b;
    s = pos;
    while (s < 2 * fill) begin
      a = store_a[s >> 1];
      b = store_b[s >> 1];
      s++;
      if (a < 1 || a > n || b < 1 || b > n) continue;
      if ((s - 1) % 2 == 0 && a == v) begin pos = s; return b; end
      if ((s - 1) % 2 == 1 && b == v) begin pos = s; return a; end
    end
    pos = s;
    return 0;
  endfunction

  function automatic void visit(int v, ref int sp);
    seen[v] = 1;
    clock_t++;
    disc[v] = clock_t;
    lowv[v] = clock_t;
    topv[v] = v;
    kids[v] = 0;
    stk_v[sp] = v;
    stk_s[sp] = 0;
    sp++;
  endfunction

  function automatic int walk_tarjan(int root, int n, ref int cuts);
    int sp, v, w, p, pos;
    bit c;
    sp = 0;
    visit(root, sp);
    while (sp > 0) begin
      v = stk_v[sp-1];
      pos = stk_s[sp-1];
      w = next_nbr(v, pos, n);
      stk_s[sp-1] = pos;
      if (w != 0) begin
        if (!seen[w]) begin
          kids[v]++;
          par[w] = v;
          if (sp <= NV) visit(w, sp);
        end else if (w != par[v] && disc[w] < lowv[v]) lowv[v] = disc[w];
        continue;
      end
      sp--;
      if (sp > 0) begin
        p = stk_v[sp-1];
        if (topv[v] > topv[p]) topv[p] = topv[v];
        if (lowv[v] < lowv[p]) lowv[p] = lowv[v];
        if (par[p] == 0) c = kids[p] > 1;
        else c = lowv[v] >= disc[p];
        if (c && !cutf[p]) begin cutf[p] = 1; cuts++; end
      end
    end
    return topv[root];
  endfunction

  function automatic int remaining(int root, int n);
    int sp, size, w, pos;
    sp = 1; size = 1;
    seen[root] = 1;
    stk_v[0] = root; stk_s[0] = 0;
    while (sp > 0) begin
      pos = stk_s[sp-1];
      w = next_nbr(stk_v[sp-1], pos, n);
      stk_s[sp-1] = pos;
      if (w == 0) begin sp--; continue; end
      if (!seen[w] && !cutf[w] && sp <= NV) begin
        seen[w] = 1;
        stk_v[sp] = w; stk_s[sp] = 0;
        sp++; size++;
      end
    end
    return size;
  endfunction

  function automatic void push_beat(logic [2:0] k, int val, bit l);
    beat_t r;
    r.kind = k; r.value = val[5:0]; r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_command(logic [1:0] op, logic [5:0] a, logic [5:0] b);
    int n, comps, cuts, best, t, s;
    n = vcount > NV ? NV : vcount;
    comps = 0; cuts = 0; best = 0;
    if (op == gapa_pkg::OP_ADD) begin
      if (a < 1 || a > n || b < 1 || b > n || fill >= NE)
        push_beat(gapa_pkg::KIND_REJECT, 0, 1);
      else begin
        store_a[fill] = a; store_b[fill] = b; fill++;
        push_beat(gapa_pkg::KIND_ACK, 0, 1);
      end
      return;
    end
    if (op == gapa_pkg::OP_CLEAR) begin
      fill = 0;
      push_beat(gapa_pkg::KIND_ACK, 0, 1);
      return;
    end
    if (op != gapa_pkg::OP_ANALYZE) begin
      push_beat(gapa_pkg::KIND_REJECT, 0, 1);
      return;
    end
    clock_t = 0;
    for (int v = 0; v <= NV; v++) begin
      par[v] = 0; seen[v] = 0; cutf[v] = 0; topf[v] = 0;
    end
    for (int v = 1; v <= n; v++)
      if (!seen[v]) begin
        t = walk_tarjan(v, n, cuts);
        if (t >= 1 && t <= n) topf[t] = 1;
        comps++;
      end
    push_beat(gapa_pkg::KIND_COMPS, comps, 0);
    for (int v = 1; v <= n; v++) if (topf[v]) push_beat(gapa_pkg::KIND_TOP, v, 0);
    push_beat(gapa_pkg::KIND_CUTS, cuts, 0);
    for (int v = 1; v <= n; v++) seen[v] = 0;
    for (int v = 1; v <= n; v++)
      if (!seen[v] && !cutf[v]) begin
        s = remaining(v, n);
        if (s > best) best = s;
      end
    push_beat(gapa_pkg::KIND_BEST, best, 1);
  endfunction

  // result checking
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat kind %0d value %0d", out_kind, out_value);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_kind); errors++;
        end
        if (out_value !== e.value) begin
          $error("value expected %0d actual %0d", e.value, out_value); errors++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (hold_req && long_hold == 0) long_hold <= 300;
    if (long_hold > 0) begin
      out_stall <= 1;
      long_hold <= long_hold - 1;
    end else if ($urandom_range(0, 3) == 0) out_stall <= 1;
    else out_stall <= 0;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [5:0] a, logic [5:0] b);
    int gap;
    gap = $urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_op <= op; in_end_a <= a; in_end_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(op, a, b);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [5:0] val);
    drain();
    cfg_valid <= 1; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    vcount = val;
  endtask

  task automatic random_graph(int nmax, int edges);
    send(gapa_pkg::OP_CLEAR, 6'($urandom), 6'($urandom));
    for (int i = 0; i < edges; i++)
      send(gapa_pkg::OP_ADD, 6'($urandom_range(1, nmax)), 6'($urandom_range(1, nmax)));
    send(gapa_pkg::OP_ANALYZE, 6'($urandom), 6'($urandom));
  endtask

  row_t dir [$];
  int sent;

  initial begin
    vcount = 1; fill = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    dir = '{
      '{gapa_pkg::OP_ANALYZE, 0, 0, 0, gapa_pkg::KIND_COMPS},
      '{gapa_pkg::OP_ADD, 1, 1, 1, gapa_pkg::KIND_ACK},
      '{gapa_pkg::OP_ADD, 0, 1, 1, gapa_pkg::KIND_REJECT},
      '{gapa_pkg::OP_ADD, 1, 2, 1, gapa_pkg::KIND_REJECT},
      '{gapa_pkg::OP_RSVD, 6'h3f, 6'h3f, 1, gapa_pkg::KIND_REJECT},
      '{gapa_pkg::OP_ANALYZE, 0, 0, 0, gapa_pkg::KIND_COMPS},
      '{gapa_pkg::OP_CLEAR, 6'h2a, 6'h15, 1, gapa_pkg::KIND_ACK}
    };
    foreach (dir[i]) begin
      send(dir[i].op, dir[i].a, dir[i].b);
      if (dir[i].has_exp && pending_results[$].kind !== dir[i].kind) begin
        $error("kind expected %0d predicted %0d", dir[i].kind, pending_results[$].kind);
        errors++;
      end
    end
    write_count(6);
    send(gapa_pkg::OP_ADD, 1, 2); send(gapa_pkg::OP_ADD, 2, 3); send(gapa_pkg::OP_ADD, 3, 1);
    send(gapa_pkg::OP_ADD, 3, 4); send(gapa_pkg::OP_ADD, 4, 5); send(gapa_pkg::OP_ADD, 4, 5);
    send(gapa_pkg::OP_ADD, 6, 6); send(gapa_pkg::OP_ADD, 7, 1); send(gapa_pkg::OP_ADD, 2, 1);
    send(gapa_pkg::OP_ANALYZE, 0, 0);
    write_count(3);
    send(gapa_pkg::OP_ANALYZE, 0, 0);
    write_count(0);
    send(gapa_pkg::OP_ANALYZE, 0, 0); send(gapa_pkg::OP_ADD, 1, 1);
    write_count(6'h3f);
    send(gapa_pkg::OP_ADD, 32, 31); send(gapa_pkg::OP_ADD, 6'h21, 1);
    send(gapa_pkg::OP_ANALYZE, 0, 0);
    sent = 25;
    // long receiver hold while commands keep coming
    write_count(12);
    hold_req = 1;
    repeat (2) @(posedge clk);
    hold_req = 0;
    random_graph(12, 20);
    sent += 22;
    drain();
    // store full
    write_count(32);
    send(gapa_pkg::OP_CLEAR, 0, 0);
    for (int i = 0; i < NE + 2; i++)
      send(gapa_pkg::OP_ADD, 6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)));
    send(gapa_pkg::OP_ANALYZE, 0, 0);
    sent += NE + 4;
    while (sent < 470) begin
      int n;
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 10);
        write_count(n[5:0]);
      end
      n = vcount > NV ? NV : (vcount == 0 ? 1 : vcount);
      if ($urandom_range(0, 4) == 0) begin
        send(2'($urandom), 6'($urandom), 6'($urandom));
        sent++;
      end else begin
        int e;
        e = $urandom_range(0, 12);
        random_graph(n, e);
        sent += e + 2;
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
